/* rtl/chit_pkg.sv */
// shared types, constants and codes of the chained hash index table
`timescale 1ns / 1ps
`default_nettype none

package chit_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = IDX_W + 1;
    localparam int LG_W        = 4;
    localparam int KEY_W       = 32;
    localparam int MODE_W      = 2;

    localparam logic [LG_W-1:0]  MAX_LG      = LG_W'(IDX_W);
    localparam logic [LG_W-1:0]  SIZE_LG_RST = LG_W'(10);
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(MAX_ENTRIES - 1);

    // command queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // input mode codes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // classified operation codes
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_LOOKUP = 2'd3;

    // input word
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  index;
    } req_word_t;

    // result word
    typedef struct packed {
        logic             status;
        logic             found;
        logic             head_valid;
        logic [IDX_W-1:0] head_index;
    } rsp_word_t;

    // one bucket head or chain link
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } slot_t;

    // classified command passed from front to back
    typedef struct packed {
        logic [1:0]       op;
        logic             bad;
        logic [IDX_W-1:0] bucket;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] mask;
    } cmd_t;

    // queue status toward the back end
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    // back end status toward the top
    typedef struct packed {
        logic init_busy;
        logic idle;
    } eng_status_t;

endpackage

`default_nettype wire

/* rtl/chit_front.sv */
// front end: size register and classification of incoming words
`timescale 1ns / 1ps
`default_nettype none

module chit_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [3:0]          cfg_data,
    input  wire chit_pkg::req_word_t req_word,
    output chit_pkg::cmd_t           cmd
);

    logic [chit_pkg::LG_W-1:0]  size_log2_reg;
    logic [chit_pkg::LG_W-1:0]  size_log2_next;
    logic [chit_pkg::LG_W-1:0]  eff_lg;
    logic [chit_pkg::CNT_W-1:0] size_full;
    logic [chit_pkg::IDX_W-1:0] mask;

    // size register, always writable
    assign cfg_ready      = 1'b1;
    assign size_log2_next = (cfg_valid && cfg_ready) ? cfg_data : size_log2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_log2_reg <= chit_pkg::SIZE_LG_RST;
        else
            size_log2_reg <= size_log2_next;
    end

    // saturate size to the table and form the mask
    assign eff_lg    = (size_log2_reg > chit_pkg::MAX_LG) ? chit_pkg::MAX_LG : size_log2_reg;
    assign size_full = chit_pkg::CNT_W'(1) << eff_lg;
    assign mask      = chit_pkg::IDX_W'(size_full - chit_pkg::CNT_W'(1));

    // classify the word
    always_comb
    begin
        cmd.bucket = req_word.key[chit_pkg::IDX_W-1:0] & mask;
        cmd.index  = req_word.index;
        cmd.mask   = mask;
        cmd.bad    = 1'b0;
        unique case (req_word.mode)
            chit_pkg::MODE_ADD,
            chit_pkg::MODE_REMOVE:
            begin
                if (req_word.index > mask)
                begin
                    cmd.op  = chit_pkg::OP_LOOKUP;
                    cmd.bad = 1'b1;
                end
                else if (req_word.mode == chit_pkg::MODE_ADD)
                    cmd.op = chit_pkg::OP_ADD;
                else
                    cmd.op = chit_pkg::OP_REMOVE;
            end
            chit_pkg::MODE_CLEAR:
                cmd.op = chit_pkg::OP_CLEAR;
            default:
                cmd.op = chit_pkg::OP_LOOKUP;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/chit_cmd_queue.sv */
// short command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module chit_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire chit_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output chit_pkg::cmd_t      head_cmd,
    output chit_pkg::q_status_t q_status
);

    chit_pkg::cmd_t                slots [chit_pkg::QDEPTH];
    logic [chit_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [chit_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [chit_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [chit_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [chit_pkg::QCNT_W-1:0]   count_reg;
    logic [chit_pkg::QCNT_W-1:0]   count_next;
    logic                          do_push;
    logic                          do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == chit_pkg::QCNT_W'(chit_pkg::QDEPTH));
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_cmd       = slots[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == chit_pkg::QPTR_W'(chit_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + chit_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == chit_pkg::QPTR_W'(chit_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + chit_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
            count_next = count_reg + chit_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - chit_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

/* rtl/chit_engine.sv */
// back end: head and link memories, operation sequencer, result register
`timescale 1ns / 1ps
`default_nettype none

module chit_engine (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire chit_pkg::q_status_t q_status,
    input  wire chit_pkg::cmd_t      q_cmd,
    output logic                     q_pop,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output chit_pkg::rsp_word_t      rsp_word,
    output chit_pkg::eng_status_t    eng_status
);

    localparam logic [2:0] S_INIT     = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_HEAD     = 3'd2;
    localparam logic [2:0] S_WALK_RD  = 3'd3;
    localparam logic [2:0] S_WALK_CHK = 3'd4;
    localparam logic [2:0] S_FIX      = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;
    localparam logic [2:0] S_CLEAR    = 3'd7;

    localparam chit_pkg::slot_t EMPTY_SLOT = '0;

    // memories
    chit_pkg::slot_t heads_mem [chit_pkg::MAX_ENTRIES];
    chit_pkg::slot_t links_mem [chit_pkg::MAX_ENTRIES];

    logic                       head_we;
    logic [chit_pkg::IDX_W-1:0] head_waddr;
    chit_pkg::slot_t            head_wdata;
    logic [chit_pkg::IDX_W-1:0] head_raddr;
    chit_pkg::slot_t            head_q;
    logic                       link_we;
    logic [chit_pkg::IDX_W-1:0] link_waddr;
    chit_pkg::slot_t            link_wdata;
    logic [chit_pkg::IDX_W-1:0] link_raddr;
    chit_pkg::slot_t            link_q;

    // sequencer registers
    logic [2:0]                 state_reg;
    logic [2:0]                 state_next;
    chit_pkg::cmd_t             cmd_reg;
    chit_pkg::cmd_t             cmd_next;
    chit_pkg::slot_t            cur_reg;
    chit_pkg::slot_t            cur_next;
    chit_pkg::slot_t            keep_reg;
    chit_pkg::slot_t            keep_next;
    logic [chit_pkg::CNT_W-1:0] steps_reg;
    logic [chit_pkg::CNT_W-1:0] steps_next;
    logic [chit_pkg::IDX_W-1:0] cnt_reg;
    logic [chit_pkg::IDX_W-1:0] cnt_next;
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;
    chit_pkg::rsp_word_t        rsp_word_reg;
    chit_pkg::rsp_word_t        rsp_word_next;
    logic                       out_free;

    function automatic chit_pkg::rsp_word_t make_rsp(
        input logic            status,
        input logic            found,
        input chit_pkg::slot_t head
    );
        chit_pkg::rsp_word_t w;
        w.status     = status;
        w.found      = found;
        w.head_valid = head.valid;
        w.head_index = head.valid ? head.idx : '0;
        return w;
    endfunction

    always_ff @(posedge clk)
    begin
        if (head_we)
            heads_mem[head_waddr] <= head_wdata;
        head_q <= heads_mem[head_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            links_mem[link_waddr] <= link_wdata;
        link_q <= links_mem[link_raddr];
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // operation sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cur_next       = cur_reg;
        keep_next      = keep_reg;
        steps_next     = steps_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_word_next  = rsp_word_reg;
        q_pop          = 1'b0;
        head_we        = 1'b0;
        head_waddr     = cmd_reg.bucket;
        head_wdata     = EMPTY_SLOT;
        head_raddr     = q_cmd.bucket;
        link_we        = 1'b0;
        link_waddr     = cmd_reg.index;
        link_wdata     = EMPTY_SLOT;
        link_raddr     = cmd_reg.index;

        unique case (state_reg)
            // sweep both memories empty after reset
            S_INIT:
            begin
                head_we    = 1'b1;
                head_waddr = cnt_reg;
                link_we    = 1'b1;
                link_waddr = cnt_reg;
                if (cnt_reg == chit_pkg::IDX_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                    cnt_next = cnt_reg + chit_pkg::IDX_W'(1);
            end

            // take a command and start the head and link reads
            S_IDLE:
            begin
                link_raddr = q_cmd.index;
                if (!q_status.empty && out_free)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    if (q_cmd.op == chit_pkg::OP_CLEAR)
                    begin
                        cnt_next   = '0;
                        state_next = S_CLEAR;
                    end
                    else
                        state_next = S_HEAD;
                end
            end

            // head of bucket and link of index are available
            S_HEAD:
            begin
                unique case (cmd_reg.op)
                    chit_pkg::OP_ADD:
                    begin
                        link_we        = 1'b1;
                        link_wdata     = head_q;
                        head_we        = 1'b1;
                        head_wdata     = {1'b1, cmd_reg.index};
                        rsp_valid_next = 1'b1;
                        rsp_word_next  = make_rsp(1'b0, 1'b0, {1'b1, cmd_reg.index});
                        state_next     = S_IDLE;
                    end
                    chit_pkg::OP_REMOVE:
                    begin
                        if (head_q.valid && head_q.idx == cmd_reg.index)
                        begin
                            head_we        = 1'b1;
                            head_wdata     = link_q;
                            link_we        = 1'b1;
                            rsp_valid_next = 1'b1;
                            rsp_word_next  = make_rsp(1'b0, 1'b1, link_q);
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            keep_next  = head_q;
                            cur_next   = head_q;
                            steps_next = '0;
                            state_next = S_WALK_RD;
                        end
                    end
                    chit_pkg::OP_LOOKUP:
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_word_next  = make_rsp(cmd_reg.bad, 1'b0, head_q);
                        state_next     = S_IDLE;
                    end
                    default:
                        state_next = S_IDLE;
                endcase
            end

            // read the link of the current chain entry, or stop the walk
            S_WALK_RD:
            begin
                if (cur_reg.valid && steps_reg <= {1'b0, cmd_reg.mask})
                begin
                    link_raddr = cur_reg.idx;
                    state_next = S_WALK_CHK;
                end
                else
                begin
                    link_we        = 1'b1;
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = make_rsp(1'b0, 1'b0, keep_reg);
                    state_next     = S_IDLE;
                end
            end

            // compare the successor with the index
            S_WALK_CHK:
            begin
                if (link_q.valid && link_q.idx == cmd_reg.index)
                    state_next = S_FIX;
                else
                begin
                    cur_next   = link_q;
                    steps_next = steps_reg + chit_pkg::CNT_W'(1);
                    state_next = S_WALK_RD;
                end
            end

            // bypass the removed entry
            S_FIX:
            begin
                link_we    = 1'b1;
                link_waddr = cur_reg.idx;
                link_wdata = link_q;
                state_next = S_FINISH;
            end

            // empty the removed entry's link
            S_FINISH:
            begin
                link_we        = 1'b1;
                rsp_valid_next = 1'b1;
                rsp_word_next  = make_rsp(1'b0, 1'b1, keep_reg);
                state_next     = S_IDLE;
            end

            // empty heads up to the configured size
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = cnt_reg;
                if (cnt_reg == cmd_reg.mask)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_word_next  = make_rsp(1'b0, 1'b0, EMPTY_SLOT);
                    state_next     = S_IDLE;
                end
                else
                    cnt_next = cnt_reg + chit_pkg::IDX_W'(1);
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        cur_reg      <= cur_next;
        keep_reg     <= keep_next;
        steps_reg    <= steps_next;
        rsp_word_reg <= rsp_word_next;
    end

    assign rsp_valid            = rsp_valid_reg;
    assign rsp_word             = rsp_word_reg;
    assign eng_status.init_busy = (state_reg == S_INIT);
    assign eng_status.idle      = (state_reg == S_IDLE);

endmodule

`default_nettype wire

/* rtl/chained_hash_index_table_unit.sv */
// top level of the chained hash index table
`timescale 1ns / 1ps
`default_nettype none

// Hash index of up to 1024 buckets and entries. Each word adds an index to the
// front of its bucket's chain, removes it (from the head or by walking the
// chain), looks up its bucket head, or empties all bucket heads up to the
// configured size, and each returns one result word with status, found and the
// bucket head afterwards. Words are classified in the front end and queued (two
// deep) for the back end, which owns the head and link memories with one read
// and one write port each and handles one word at a time, walking a chain one
// entry after another. After reset the block sweeps both memories and holds
// req_stall high meanwhile; cfg writes are taken at any time.
module chained_hash_index_table_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [3:0]          cfg_data,
    input  wire logic                req_valid,
    output logic                     req_stall,
    input  wire chit_pkg::req_word_t req_word,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    output chit_pkg::rsp_word_t      rsp_word
);

    chit_pkg::cmd_t        front_cmd;
    chit_pkg::cmd_t        q_cmd;
    chit_pkg::q_status_t   q_status;
    chit_pkg::eng_status_t eng_status;
    logic                  q_pop;
    logic                  q_push;

    // accept words once the memories are swept and the queue has room
    assign req_stall = q_status.full || eng_status.init_busy;
    assign q_push    = req_valid && !req_stall;

    chit_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .req_word  (req_word),
        .cmd       (front_cmd)
    );

    chit_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (front_cmd),
        .pop      (q_pop),
        .head_cmd (q_cmd),
        .q_status (q_status)
    );

    chit_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_cmd      (q_cmd),
        .q_pop      (q_pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word),
        .eng_status (eng_status)
    );

    // no result while the memories are being swept
    a_no_rsp_in_init: assert property (@(posedge clk) disable iff (!rst_n)
        eng_status.init_busy |-> !rsp_valid)
        else $error("result word during memory sweep");

    // the back end takes a word only from a nonempty queue while idle
    a_pop_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!q_status.empty && eng_status.idle))
        else $error("queue popped while empty or busy");

    // an empty head reports index zero
    a_empty_head_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_word.head_valid) |-> (rsp_word.head_index == '0))
        else $error("empty head with nonzero index");

    // a rejected index is never reported as found
    a_bad_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_word.status) |-> !rsp_word.found)
        else $error("rejected index reported as found");

endmodule

`default_nettype wire
